>>> hdl/spq_pkg.sv
// Shared types and default sizes for the sorted priority queue.
// No dependencies; every other file in this folder uses it.
package spq_pkg;

	localparam int DEPTH_DEF        = 16;
	localparam int KEY_BITS_DEF     = 16;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int COUNT_OUT_BITS   = 5;

	localparam logic ACTION_PUSH = 1'b0;
	localparam logic ACTION_POP  = 1'b1;

	localparam logic ORDER_LARGEST_FIRST  = 1'b0;
	localparam logic ORDER_SMALLEST_FIRST = 1'b1;

	// broadcast to every cell of the row
	typedef struct packed {
		logic push;
		logic pop;
		logic order_mode;
	} spq_ctrl_t;

endpackage

>>> hdl/spq_if.sv
// Request and response channels of the sorted priority queue.
// Depends on spq_pkg for default widths.
interface spq_req_if #(
	parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic                    action;
	logic [KEY_BITS-1:0]     key;
	logic [PAYLOAD_BITS-1:0] payload;

	modport source (output valid, output action, output key, output payload, input ready);
	modport sink   (input valid, input action, input key, input payload, output ready);
endinterface

interface spq_rsp_if #(
	parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic                              push_accepted;
	logic                              pop_valid;
	logic [KEY_BITS-1:0]               out_key;
	logic [PAYLOAD_BITS-1:0]           out_payload;
	logic                              is_empty;
	logic                              is_full;
	logic [spq_pkg::COUNT_OUT_BITS-1:0] entry_count;

	modport source (output valid, output push_accepted, output pop_valid, output out_key,
		output out_payload, output is_empty, output is_full, output entry_count,
		input ready);
	modport sink   (input valid, input push_accepted, input pop_valid, input out_key,
		input out_payload, input is_empty, input is_full, input entry_count,
		output ready);
endinterface

>>> hdl/spq_cell.sv
// One slot of the sorted row: holds a key and payload, compares against the
// incoming key and shifts towards the tail on insert or the head on pop.
// Depends on spq_pkg.
module spq_cell #(
	parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                    clk,
	input  spq_pkg::spq_ctrl_t      ctrl,
	input  logic                    occupied,
	input  logic [KEY_BITS-1:0]     new_key,
	input  logic [PAYLOAD_BITS-1:0] new_payload,
	input  logic                    prev_le,
	input  logic [KEY_BITS-1:0]     prev_key,
	input  logic [PAYLOAD_BITS-1:0] prev_payload,
	input  logic [KEY_BITS-1:0]     next_key,
	input  logic [PAYLOAD_BITS-1:0] next_payload,
	output logic                    le,
	output logic [KEY_BITS-1:0]     key_q,
	output logic [PAYLOAD_BITS-1:0] payload_q
);

	logic goes_first;

	always_comb begin
		if (ctrl.order_mode == spq_pkg::ORDER_SMALLEST_FIRST) begin
			goes_first = (new_key <= key_q);
		end else begin
			goes_first = (new_key >= key_q);
		end
	end

	// set from the insertion point to the tail; an empty slot counts as one
	assign le = prev_le || !occupied || goes_first;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (le && prev_le) begin
				key_q     <= prev_key;
				payload_q <= prev_payload;
			end else if (le) begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end
		end else if (ctrl.pop) begin
			key_q     <= next_key;
			payload_q <= next_payload;
		end
	end

endmodule

>>> hdl/sorted_priority_queue.sv
// Sorted priority queue, top level: a row of DEPTH cells kept in service order.
// Depends on spq_pkg, spq_req_if/spq_rsp_if and spq_cell.
//
// Takes one push or pop request per clock cycle and returns its response in the
// next cycle from an output register; a new request is taken whenever that
// register is empty or being drained. Each push compares the new key against
// every cell at once and the row shifts by one slot in the same cycle, so the
// rate is one request per cycle at any DEPTH. order_mode (0: largest key first,
// 1: smallest key first) applies to later pushes; held entries keep their order.
// Among equal keys the newest entry leaves first.
module sorted_priority_queue #(
	parameter int DEPTH        = spq_pkg::DEPTH_DEF,
	parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  logic   cfg_wdata,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

	logic                    order_mode_q;
	logic [CNT_BITS-1:0]     count_q;
	logic [CNT_BITS-1:0]     count_d;
	logic                    accept;
	logic                    full;
	logic                    empty;
	logic                    push_ok;
	logic                    pop_ok;
	spq_pkg::spq_ctrl_t      ctrl;

	logic                    occ_w      [DEPTH];
	logic                    le_w       [DEPTH];
	logic                    prev_le_w  [DEPTH];
	logic [KEY_BITS-1:0]     key_w      [DEPTH];
	logic [PAYLOAD_BITS-1:0] payload_w  [DEPTH];
	logic [KEY_BITS-1:0]     prev_key_w [DEPTH];
	logic [PAYLOAD_BITS-1:0] prev_pay_w [DEPTH];
	logic [KEY_BITS-1:0]     next_key_w [DEPTH];
	logic [PAYLOAD_BITS-1:0] next_pay_w [DEPTH];

	logic                    rsp_valid_q;
	logic                    push_accepted_q;
	logic                    pop_valid_q;
	logic [KEY_BITS-1:0]     out_key_q;
	logic [PAYLOAD_BITS-1:0] out_payload_q;
	logic                    is_empty_q;
	logic                    is_full_q;
	logic [spq_pkg::COUNT_OUT_BITS-1:0] entry_count_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign push_ok   = accept && (req.action == spq_pkg::ACTION_PUSH) && !full;
	assign pop_ok    = accept && (req.action == spq_pkg::ACTION_POP) && !empty;

	always_comb begin
		count_d = count_q;
		if (push_ok) begin
			count_d = count_q + CNT_BITS'(1);
		end else if (pop_ok) begin
			count_d = count_q - CNT_BITS'(1);
		end
	end

	assign ctrl.push       = push_ok;
	assign ctrl.pop        = pop_ok;
	assign ctrl.order_mode = order_mode_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ_w[i] = (CNT_BITS'(i) < count_q);

		if (i == 0) begin : g_head
			assign prev_le_w[i]  = 1'b0;
			assign prev_key_w[i] = req.key;
			assign prev_pay_w[i] = req.payload;
		end else begin : g_body
			assign prev_le_w[i]  = le_w[i-1];
			assign prev_key_w[i] = key_w[i-1];
			assign prev_pay_w[i] = payload_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_key_w[i] = key_w[i];
			assign next_pay_w[i] = payload_w[i];
		end else begin : g_link
			assign next_key_w[i] = key_w[i+1];
			assign next_pay_w[i] = payload_w[i+1];
		end

		spq_cell #(
			.KEY_BITS     (KEY_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS)
		) u_cell (
			.clk          (clk),
			.ctrl         (ctrl),
			.occupied     (occ_w[i]),
			.new_key      (req.key),
			.new_payload  (req.payload),
			.prev_le      (prev_le_w[i]),
			.prev_key     (prev_key_w[i]),
			.prev_payload (prev_pay_w[i]),
			.next_key     (next_key_w[i]),
			.next_payload (next_pay_w[i]),
			.le           (le_w[i]),
			.key_q        (key_w[i]),
			.payload_q    (payload_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= spq_pkg::ORDER_LARGEST_FIRST;
			count_q      <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				order_mode_q <= cfg_wdata;
			end
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			push_accepted_q <= push_ok;
			pop_valid_q     <= pop_ok;
			out_key_q       <= pop_ok ? key_w[0] : '0;
			out_payload_q   <= pop_ok ? payload_w[0] : '0;
			is_empty_q      <= (count_d == '0);
			is_full_q       <= (count_d == FULL_CNT);
			entry_count_q   <= spq_pkg::COUNT_OUT_BITS'(count_d);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.push_accepted = push_accepted_q;
	assign rsp.pop_valid     = pop_valid_q;
	assign rsp.out_key       = out_key_q;
	assign rsp.out_payload   = out_payload_q;
	assign rsp.is_empty      = is_empty_q;
	assign rsp.is_full       = is_full_q;
	assign rsp.entry_count   = entry_count_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("occupancy beyond depth");

	a_full_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.action == spq_pkg::ACTION_PUSH) && full) |=> $stable(count_q))
		else $error("push into full queue changed occupancy");

	a_rsp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(push_accepted_q && pop_valid_q))
		else $error("response flags both push and pop");

	a_empty_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && is_empty_q) |-> (count_q == '0))
		else $error("empty flag disagrees with occupancy");
`endif

endmodule

>>> tb/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps
// Testbench for sorted_priority_queue: directed table then random push/pop traffic.
// Depends on spq_pkg, spq_req_if/spq_rsp_if and the RTL; responses checked against model or plan.
module tb_sorted_priority_queue;

	localparam int DEPTH = spq_pkg::DEPTH_DEF;
	localparam int KB    = spq_pkg::KEY_BITS_DEF;
	localparam int PB    = spq_pkg::PAYLOAD_BITS_DEF;
	localparam int CB    = spq_pkg::COUNT_OUT_BITS;
	localparam int PHASE_REQUESTS = 350;

	typedef struct packed {
		logic          push_accepted;
		logic          pop_valid;
		logic [KB-1:0] out_key;
		logic [PB-1:0] out_payload;
		logic          is_empty;
		logic          is_full;
		logic [CB-1:0] entry_count;
	} outcome_t;

	typedef struct {
		logic          act;
		logic [KB-1:0] key;
		logic [PB-1:0] payload;
		bit            typed;
		outcome_t      want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	spq_req_if #(.KEY_BITS(KB), .PAYLOAD_BITS(PB)) req();
	spq_rsp_if #(.KEY_BITS(KB), .PAYLOAD_BITS(PB)) rsp();

	sorted_priority_queue #(.DEPTH(DEPTH), .KEY_BITS(KB), .PAYLOAD_BITS(PB)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.rsp      (rsp)
	);

	// model state
	logic [KB-1:0] held_key [DEPTH];
	logic [PB-1:0] held_payload [DEPTH];
	int            fill;
	logic          order_mode;

	outcome_t  awaited[$];
	outcome_t  arrived;
	int        mismatches;
	plan_row_t plan [24];

	function automatic outcome_t apply_request(logic act, logic [KB-1:0] k, logic [PB-1:0] p);
		outcome_t r;
		int       slot;
		r = '0;
		if (act == spq_pkg::ACTION_PUSH) begin
			if (fill < DEPTH) begin
				slot = fill;
				for (int i = 0; i < fill; i++) begin
					if (slot == fill &&
						(order_mode == spq_pkg::ORDER_SMALLEST_FIRST ?
							k <= held_key[i] : k >= held_key[i]))
						slot = i;
				end
				for (int i = fill; i > slot; i--) begin
					held_key[i]     = held_key[i-1];
					held_payload[i] = held_payload[i-1];
				end
				held_key[slot]     = k;
				held_payload[slot] = p;
				fill++;
				r.push_accepted = 1'b1;
			end
		end else if (fill > 0) begin
			r.pop_valid   = 1'b1;
			r.out_key     = held_key[0];
			r.out_payload = held_payload[0];
			for (int i = 1; i < fill; i++) begin
				held_key[i-1]     = held_key[i];
				held_payload[i-1] = held_payload[i];
			end
			fill--;
		end
		r.is_empty    = (fill == 0);
		r.is_full     = (fill == DEPTH);
		r.entry_count = CB'(fill);
		return r;
	endfunction

	function automatic void check_field(string name, logic [PB-1:0] want, logic [PB-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// called on a rising edge; returns on the edge the request is taken
	task automatic offer(logic act, logic [KB-1:0] k, logic [PB-1:0] p,
		bit typed = 1'b0, outcome_t want = '0);
		outcome_t model_out;
		req.valid   <= 1'b1;
		req.action  <= act;
		req.key     <= k;
		req.payload <= p;
		do @(posedge clk); while (req.ready !== 1'b1);
		model_out = apply_request(act, k, p);
		awaited.push_back(typed ? want : model_out);
	endtask

	// empty the queue, let it settle, then change the order
	task automatic set_order(logic m);
		while (fill > 0)
			offer(spq_pkg::ACTION_POP, KB'($urandom), PB'($urandom));
		req.valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we     <= 1'b0;
		order_mode = m;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// receiver: free-running, with always-ready, random and long hold-off stretches
	initial begin
		int n;
		int kind;
		int idx;
		idx = 0;
		rsp.ready = 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			kind = (idx == 3 || $urandom_range(0, 31) == 0) ? 2 : $urandom_range(0, 1);
			case (kind)
				0: begin
					n = $urandom_range(4, 40);
					repeat (n) begin
						rsp.ready <= 1'b1;
						@(posedge clk);
					end
				end
				1: begin
					n = $urandom_range(4, 40);
					repeat (n) begin
						rsp.ready <= 1'($urandom_range(0, 1));
						@(posedge clk);
					end
				end
				default: begin
					rsp.ready <= 1'b0;
					n = $urandom_range(60, 120);
					repeat (n) @(posedge clk);
				end
			endcase
			idx++;
		end
	end

	always @(posedge clk) begin
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (awaited.size() == 0) begin
				$error("response with no request outstanding");
				mismatches++;
			end else begin
				arrived = awaited.pop_front();
				check_field("push_accepted", PB'(arrived.push_accepted),
					PB'(rsp.push_accepted));
				check_field("pop_valid", PB'(arrived.pop_valid), PB'(rsp.pop_valid));
				check_field("out_key", PB'(arrived.out_key), PB'(rsp.out_key));
				check_field("out_payload", arrived.out_payload, rsp.out_payload);
				check_field("is_empty", PB'(arrived.is_empty), PB'(rsp.is_empty));
				check_field("is_full", PB'(arrived.is_full), PB'(rsp.is_full));
				check_field("entry_count", PB'(arrived.entry_count), PB'(rsp.entry_count));
			end
		end
	end

	initial begin
		int            seg_left;
		int            push_pct;
		int            burst_left;
		logic          act;
		logic [KB-1:0] k;

		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = 1'b0;
		req.valid   = 1'b0;
		req.action  = spq_pkg::ACTION_PUSH;
		req.key     = '0;
		req.payload = '0;
		fill        = 0;
		order_mode  = spq_pkg::ORDER_LARGEST_FIRST;
		mismatches  = 0;
		seg_left    = 0;
		push_pct    = 50;
		burst_left  = 0;

		plan = '{
			'{spq_pkg::ACTION_POP,  16'h0000, 32'h00000000, 1'b1,
				'{1'b0, 1'b0, 16'h0000, 32'h00000000, 1'b1, 1'b0, 5'd0}},
			'{spq_pkg::ACTION_PUSH, 16'h0000, 32'h00000000, 1'b1,
				'{1'b1, 1'b0, 16'h0000, 32'h00000000, 1'b0, 1'b0, 5'd1}},
			'{spq_pkg::ACTION_PUSH, 16'hFFFF, 32'hFFFFFFFF, 1'b1,
				'{1'b1, 1'b0, 16'h0000, 32'h00000000, 1'b0, 1'b0, 5'd2}},
			'{spq_pkg::ACTION_PUSH, 16'h8000, 32'hA5A5A5A5, 1'b0, '0},
			'{spq_pkg::ACTION_PUSH, 16'hFFFF, 32'h5A5A5A5A, 1'b0, '0},
			'{spq_pkg::ACTION_POP,  16'hFFFF, 32'hFFFFFFFF, 1'b1,
				'{1'b0, 1'b1, 16'hFFFF, 32'h5A5A5A5A, 1'b0, 1'b0, 5'd3}},
			'{spq_pkg::ACTION_POP,  16'h0000, 32'h00000000, 1'b1,
				'{1'b0, 1'b1, 16'hFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, 5'd2}},
			'{spq_pkg::ACTION_PUSH, 16'h8000, 32'h00000001, 1'b0, '0},
			'{spq_pkg::ACTION_PUSH, 16'h0001, 32'h80000000, 1'b0, '0},
			'{spq_pkg::ACTION_PUSH, 16'h7FFF, 32'h7FFFFFFF, 1'b0, '0},
			'{spq_pkg::ACTION_PUSH, 16'h8001, 32'h01234567, 1'b0, '0},
			'{spq_pkg::ACTION_PUSH, 16'h0000, 32'h89ABCDEF, 1'b0, '0},
			'{spq_pkg::ACTION_PUSH, 16'hFFFE, 32'hFEDCBA98, 1'b0, '0},
			'{spq_pkg::ACTION_PUSH, 16'h1234, 32'h76543210, 1'b0, '0},
			'{spq_pkg::ACTION_PUSH, 16'h8000, 32'h0F0F0F0F, 1'b0, '0},
			'{spq_pkg::ACTION_PUSH, 16'h00FF, 32'hF0F0F0F0, 1'b0, '0},
			'{spq_pkg::ACTION_PUSH, 16'hFF00, 32'h33333333, 1'b0, '0},
			'{spq_pkg::ACTION_PUSH, 16'h4000, 32'hCCCCCCCC, 1'b0, '0},
			'{spq_pkg::ACTION_PUSH, 16'hC000, 32'h55555555, 1'b0, '0},
			'{spq_pkg::ACTION_PUSH, 16'h0002, 32'hAAAAAAAA, 1'b0, '0},
			'{spq_pkg::ACTION_PUSH, 16'hAAAA, 32'h11111111, 1'b0, '0},
			'{spq_pkg::ACTION_PUSH, 16'hFFFF, 32'h13579BDF, 1'b1,
				'{1'b0, 1'b0, 16'h0000, 32'h00000000, 1'b0, 1'b1, 5'd16}},
			'{spq_pkg::ACTION_POP,  16'h0000, 32'h00000000, 1'b0, '0},
			'{spq_pkg::ACTION_POP,  16'hFFFF, 32'hFFFFFFFF, 1'b0, '0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			offer(plan[i].act, plan[i].key, plan[i].payload, plan[i].typed, plan[i].want);

		for (int ph = 0; ph < 4; ph++) begin
			set_order(ph % 2 == 0 ? spq_pkg::ORDER_SMALLEST_FIRST :
				spq_pkg::ORDER_LARGEST_FIRST);
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(20, 80);
					case ($urandom_range(0, 3))
						0: push_pct = 25;
						1: push_pct = 50;
						2: push_pct = 75;
						default: push_pct = 90;
					endcase
				end
				seg_left--;
				if (burst_left == 0) begin
					if ($urandom_range(0, 3) != 0) begin
						req.valid <= 1'b0;
						repeat ($urandom_range(1, 8)) @(posedge clk);
					end
					burst_left = $urandom_range(1, 24);
				end
				burst_left--;
				act = ($urandom_range(0, 99) < push_pct) ? spq_pkg::ACTION_PUSH :
					spq_pkg::ACTION_POP;
				case ($urandom_range(0, 3))
					0: k = $urandom_range(0, 1) ? {KB{1'b1}} : '0;
					1: k = KB'($urandom_range(0, 7));
					2: k = {KB{1'b1}} - KB'($urandom_range(0, 7));
					default: k = KB'($urandom);
				endcase
				offer(act, k, PB'($urandom));
			end
		end

		req.valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
